// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the sparse triplet merge block.
// Synthesis builds see empty bodies; simulation sees concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hw/rtl/stma_pkg.sv =====
// Package for the sparse triplet merge block: sizes, widths and opcodes.
// Used by sparse_triplet_merge_add_top and by the checker and testbench.
`timescale 1ns / 1ps

package stma_pkg;

    localparam int MAX_TERMS  = 32;
    localparam int INDEX_BITS = 8;
    localparam int VALUE_BITS = 16;

    // Port widths of the words, fixed by the interface.
    localparam int ROW_PORT_W   = 8;
    localparam int VALUE_PORT_W = 16;
    localparam int SUM_PORT_W   = 17;
    localparam int COUNT_PORT_W = 7;

    localparam int SUM_W   = VALUE_BITS + 1;
    localparam int WORD_W  = 2 * INDEX_BITS + VALUE_BITS;
    localparam int ADDR_W  = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int CNT_W   = $clog2(MAX_TERMS + 1);
    localparam int TOTAL_W = $clog2(2 * MAX_TERMS + 1);

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_LOAD_A = 2'd1,
        OP_LOAD_B = 2'd2,
        OP_RUN    = 2'd3
    } t_opcode;

endpackage

// ===== hw/rtl/stma_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; holds one term store of the merge block.
`timescale 1ns / 1ps

module stma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/sparse_triplet_merge_add_top.sv =====
// Top level of the sparse triplet merge block: two term stores and the merge engine.
// Depends on stma_pkg, stma_ram and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Channel   Direction  Handshake          Word
// command   in         start, busy        i_opcode, i_term_row, i_term_col, i_term_value
// result    out        o_valid (strobe)   o_has_term, o_out_row, o_out_col, o_out_value,
//                                          o_last, o_term_count, o_overflow
//
// Clear and load commands are done once accepted; busy stays low for them.
// A run stays busy through each merge step (a matched pair is a single step, so
// at most 64), through the check that sees that the walk has ended and through the
// building of the closing word, which shows in the same cycle as busy falls; the walk
// through the store RAMs sets how long a run stays busy.
// Reset (i_rst_n low at a clock edge) empties both stores and clears the overflow flag.
// Each result word is shown for exactly one cycle; the receiver cannot stall it.

module sparse_triplet_merge_add_top
    import stma_pkg::*;
(
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     i_opcode,
    input  logic [ROW_PORT_W-1:0]          i_term_row,
    input  logic [ROW_PORT_W-1:0]          i_term_col,
    input  logic signed [VALUE_PORT_W-1:0] i_term_value,
    output logic                           o_valid,
    output logic                           o_has_term,
    output logic [ROW_PORT_W-1:0]          o_out_row,
    output logic [ROW_PORT_W-1:0]          o_out_col,
    output logic signed [SUM_PORT_W-1:0]   o_out_value,
    output logic                           o_last,
    output logic [COUNT_PORT_W-1:0]        o_term_count,
    output logic                           o_overflow
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MERGE,
        S_LAST
    } t_state;

    t_state r_state;

    // Store fill counts and the sticky overflow flag.
    logic [CNT_W-1:0] r_cnt_a;
    logic [CNT_W-1:0] r_cnt_b;
    logic             r_ovf;

    // Merge walk indices and the running count of result terms.
    logic [CNT_W-1:0]   r_i;
    logic [CNT_W-1:0]   r_j;
    logic [CNT_W-1:0]   n_i;
    logic [CNT_W-1:0]   n_j;
    logic [TOTAL_W-1:0] r_n;

    // One-term holding register: a term is only known to be the last one
    // once the walk has ended, so each term waits here until the next one
    // (or the end of the walk) arrives.
    logic                    r_pend_v;
    logic [INDEX_BITS-1:0]   r_pend_row;
    logic [INDEX_BITS-1:0]   r_pend_col;
    logic signed [SUM_W-1:0] r_pend_value;

    // Registered result word.
    logic                           r_out_valid;
    logic                           r_out_has;
    logic [ROW_PORT_W-1:0]          r_out_row;
    logic [ROW_PORT_W-1:0]          r_out_col;
    logic signed [SUM_PORT_W-1:0]   r_out_value;
    logic                           r_out_last;
    logic [COUNT_PORT_W-1:0]        r_out_count;

    // Load path.
    logic                          accept;
    logic [INDEX_BITS-1:0]         ld_row;
    logic [INDEX_BITS-1:0]         ld_col;
    logic signed [VALUE_BITS-1:0]  ld_value;
    logic                          ld_nonzero;
    logic                          full_a;
    logic                          full_b;
    logic                          we_a;
    logic                          we_b;
    logic [WORD_W-1:0]             wdata;

    // Read path.
    logic [ADDR_W-1:0] raddr_a;
    logic [ADDR_W-1:0] raddr_b;
    logic [WORD_W-1:0] rdata_a;
    logic [WORD_W-1:0] rdata_b;

    logic [INDEX_BITS-1:0]        a_row;
    logic [INDEX_BITS-1:0]        a_col;
    logic signed [VALUE_BITS-1:0] a_val;
    logic [INDEX_BITS-1:0]        b_row;
    logic [INDEX_BITS-1:0]        b_col;
    logic signed [VALUE_BITS-1:0] b_val;
    logic                         a_v;
    logic                         b_v;
    logic signed [SUM_W-1:0]      sum_ab;

    // Candidate term produced by this merge step.
    logic                    cand_v;
    logic [INDEX_BITS-1:0]   cand_row;
    logic [INDEX_BITS-1:0]   cand_col;
    logic signed [SUM_W-1:0] cand_value;

    assign accept     = start && (r_state == S_IDLE);
    assign busy       = (r_state != S_IDLE);
    assign ld_row     = i_term_row[INDEX_BITS-1:0];
    assign ld_col     = i_term_col[INDEX_BITS-1:0];
    assign ld_value   = i_term_value[VALUE_BITS-1:0];
    assign ld_nonzero = (ld_value != '0);
    assign full_a     = (r_cnt_a >= CNT_W'(MAX_TERMS));
    assign full_b     = (r_cnt_b >= CNT_W'(MAX_TERMS));
    assign wdata      = {ld_row, ld_col, ld_value};
    assign we_a = accept && (i_opcode == OP_LOAD_A) && ld_nonzero && !full_a;
    assign we_b = accept && (i_opcode == OP_LOAD_B) && ld_nonzero && !full_b;

    assign a_row = rdata_a[WORD_W-1 -: INDEX_BITS];
    assign a_col = rdata_a[VALUE_BITS +: INDEX_BITS];
    assign a_val = rdata_a[VALUE_BITS-1:0];
    assign b_row = rdata_b[WORD_W-1 -: INDEX_BITS];
    assign b_col = rdata_b[VALUE_BITS +: INDEX_BITS];
    assign b_val = rdata_b[VALUE_BITS-1:0];

    assign a_v    = (r_i < r_cnt_a);
    assign b_v    = (r_j < r_cnt_b);
    assign sum_ab = SUM_W'(a_val) + SUM_W'(b_val);

    // One merge step. The RAM holds the entries at r_i and r_j on its read
    // ports; the next indices go straight to the read address so that the
    // following entries are ready in the next cycle.
    always_comb begin
        n_i        = r_i;
        n_j        = r_j;
        cand_v     = 1'b0;
        cand_row   = a_row;
        cand_col   = a_col;
        cand_value = SUM_W'(a_val);
        if (r_state == S_MERGE) begin
            if (a_v && b_v) begin
                if ({a_row, a_col} < {b_row, b_col}) begin
                    cand_v = 1'b1;
                    n_i    = r_i + CNT_W'(1);
                end else if ({b_row, b_col} < {a_row, a_col}) begin
                    cand_v     = 1'b1;
                    cand_row   = b_row;
                    cand_col   = b_col;
                    cand_value = SUM_W'(b_val);
                    n_j        = r_j + CNT_W'(1);
                end else begin
                    // Same position: add, and drop the term if it cancels.
                    cand_v     = (sum_ab != '0);
                    cand_value = sum_ab;
                    n_i        = r_i + CNT_W'(1);
                    n_j        = r_j + CNT_W'(1);
                end
            end else if (a_v) begin
                cand_v = 1'b1;
                n_i    = r_i + CNT_W'(1);
            end else if (b_v) begin
                cand_v     = 1'b1;
                cand_row   = b_row;
                cand_col   = b_col;
                cand_value = SUM_W'(b_val);
                n_j        = r_j + CNT_W'(1);
            end
        end
    end

    // Outside a run the read ports sit at entry zero, which is where a run starts.
    assign raddr_a = (r_state == S_MERGE) ? n_i[ADDR_W-1:0] : '0;
    assign raddr_b = (r_state == S_MERGE) ? n_j[ADDR_W-1:0] : '0;

    stma_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_TERMS)
    ) u_store_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (r_cnt_a[ADDR_W-1:0]),
        .i_wdata (wdata),
        .i_raddr (raddr_a),
        .o_rdata (rdata_a)
    );

    stma_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_TERMS)
    ) u_store_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (r_cnt_b[ADDR_W-1:0]),
        .i_wdata (wdata),
        .i_raddr (raddr_b),
        .o_rdata (rdata_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt_a     <= '0;
            r_cnt_b     <= '0;
            r_ovf       <= 1'b0;
            r_i         <= '0;
            r_j         <= '0;
            r_n         <= '0;
            r_pend_v    <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_last  <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        case (i_opcode)
                            OP_CLEAR: begin
                                r_cnt_a <= '0;
                                r_cnt_b <= '0;
                                r_ovf   <= 1'b0;
                            end
                            OP_LOAD_A: begin
                                if (ld_nonzero) begin
                                    if (full_a) begin
                                        r_ovf <= 1'b1;
                                    end else begin
                                        r_cnt_a <= r_cnt_a + CNT_W'(1);
                                    end
                                end
                            end
                            OP_LOAD_B: begin
                                if (ld_nonzero) begin
                                    if (full_b) begin
                                        r_ovf <= 1'b1;
                                    end else begin
                                        r_cnt_b <= r_cnt_b + CNT_W'(1);
                                    end
                                end
                            end
                            OP_RUN: begin
                                r_i      <= '0;
                                r_j      <= '0;
                                r_n      <= '0;
                                r_pend_v <= 1'b0;
                                r_state  <= S_MERGE;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_MERGE: begin
                    r_i <= n_i;
                    r_j <= n_j;
                    if (cand_v) begin
                        if (r_pend_v) begin
                            r_out_valid <= 1'b1;
                            r_out_has   <= 1'b1;
                            r_out_row   <= ROW_PORT_W'(r_pend_row);
                            r_out_col   <= ROW_PORT_W'(r_pend_col);
                            r_out_value <= SUM_PORT_W'(r_pend_value);
                            r_out_last  <= 1'b0;
                            r_out_count <= '0;
                        end
                        r_pend_v     <= 1'b1;
                        r_pend_row   <= cand_row;
                        r_pend_col   <= cand_col;
                        r_pend_value <= cand_value;
                        r_n          <= r_n + TOTAL_W'(1);
                    end
                    if (!a_v && !b_v) begin
                        r_state <= S_LAST;
                    end
                end
                S_LAST: begin
                    // Closing word: the held term with the count, or an empty marker.
                    r_out_valid <= 1'b1;
                    r_out_last  <= 1'b1;
                    if (r_pend_v) begin
                        r_out_has   <= 1'b1;
                        r_out_row   <= ROW_PORT_W'(r_pend_row);
                        r_out_col   <= ROW_PORT_W'(r_pend_col);
                        r_out_value <= SUM_PORT_W'(r_pend_value);
                        r_out_count <= COUNT_PORT_W'(r_n);
                    end else begin
                        r_out_has   <= 1'b0;
                        r_out_row   <= '0;
                        r_out_col   <= '0;
                        r_out_value <= '0;
                        r_out_count <= '0;
                    end
                    r_pend_v <= 1'b0;
                    r_state  <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // The overflow flag cannot change during a run, so it is shown live.
    assign o_valid      = r_out_valid;
    assign o_has_term   = r_out_has;
    assign o_out_row    = r_out_row;
    assign o_out_col    = r_out_col;
    assign o_out_value  = r_out_value;
    assign o_last       = r_out_last;
    assign o_term_count = r_out_count;
    assign o_overflow   = r_ovf;

    // Only the closing word of a run may lack a term.
    `ASSERT_IMPLIES(a_mid_has_term, i_clk, i_rst_n, o_valid && !o_last, o_has_term)
    // The closing word is never directly followed by another word.
    `ASSERT_NEXT(a_last_gap, i_clk, i_rst_n, o_valid && o_last, !o_valid)
    // The walk never runs past the fill count of either store.
    `ASSERT_IMPLIES(a_walk_bounds, i_clk, i_rst_n, r_state == S_MERGE, (r_i <= r_cnt_a) && (r_j <= r_cnt_b))
    // Every result term consumes at least one stored term.
    `ASSERT_IMPLIES(a_count_bound, i_clk, i_rst_n, r_state != S_IDLE, r_n <= (TOTAL_W'(r_i) + TOTAL_W'(r_j)))

endmodule

// ===== tb/sparse_triplet_merge_add_checker.sv =====
// Checker for the sparse triplet merge block: watches the command and result channels,
// keeps its own copy of both term stores and predicts every result word of a merge run.
// Depends on stma_pkg for widths and opcodes.
`timescale 1ns / 1ps

module sparse_triplet_merge_add_checker
    import stma_pkg::*;
(
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    input  logic                           busy,
    input  logic [1:0]                     i_opcode,
    input  logic [ROW_PORT_W-1:0]          i_term_row,
    input  logic [ROW_PORT_W-1:0]          i_term_col,
    input  logic signed [VALUE_PORT_W-1:0] i_term_value,
    input  logic                           i_valid,
    input  logic                           i_has_term,
    input  logic [ROW_PORT_W-1:0]          i_out_row,
    input  logic [ROW_PORT_W-1:0]          i_out_col,
    input  logic signed [SUM_PORT_W-1:0]   i_out_value,
    input  logic                           i_last,
    input  logic [COUNT_PORT_W-1:0]        i_term_count,
    input  logic                           i_overflow,
    output int                             o_mismatch_count,
    output int                             o_pending_words
);

    localparam int STORE_A = 0;
    localparam int STORE_B = 1;
    localparam int REPORT_LIMIT = 10;

    typedef struct {
        logic [INDEX_BITS-1:0]        row;
        logic [INDEX_BITS-1:0]        col;
        logic signed [VALUE_BITS-1:0] value;
    } t_term;

    typedef struct {
        logic                      has_term;
        logic [ROW_PORT_W-1:0]     row;
        logic [ROW_PORT_W-1:0]     col;
        logic signed [SUM_W-1:0]   value;
        logic                      last;
        logic [COUNT_PORT_W-1:0]   count;
        logic                      overflow;
    } t_sum_word;

    t_term     terms [2][MAX_TERMS];
    int        term_len [2];
    logic      dropped_load;
    t_sum_word sum_word_q[$];
    t_sum_word want;
    int        store_sel;

    function automatic t_sum_word term_word(logic [INDEX_BITS-1:0] row,
                                            logic [INDEX_BITS-1:0] col,
                                            logic signed [SUM_W-1:0] value);
        t_sum_word w;
        w.has_term = 1'b1;
        w.row      = row;
        w.col      = col;
        w.value    = value;
        w.last     = 1'b0;
        w.count    = '0;
        w.overflow = dropped_load;
        return w;
    endfunction

    // Walks both stores in stored order, merging by row-major position, and queues the words of one run.
    task automatic merge_stores();
        int                      i;
        int                      j;
        t_term                   ta;
        t_term                   tb;
        logic signed [SUM_W-1:0] s;
        t_sum_word               run_q[$];
        t_sum_word               w;
        i = 0;
        j = 0;
        while (i < term_len[STORE_A] && j < term_len[STORE_B]) begin
            ta = terms[STORE_A][i];
            tb = terms[STORE_B][j];
            if ({ta.row, ta.col} < {tb.row, tb.col}) begin
                run_q.push_back(term_word(ta.row, ta.col, ta.value));
                i++;
            end else if ({tb.row, tb.col} < {ta.row, ta.col}) begin
                run_q.push_back(term_word(tb.row, tb.col, tb.value));
                j++;
            end else begin
                s = ta.value + tb.value;
                if (s != 0) begin
                    run_q.push_back(term_word(ta.row, ta.col, s));
                end
                i++;
                j++;
            end
        end
        for (; i < term_len[STORE_A]; i++) begin
            ta = terms[STORE_A][i];
            run_q.push_back(term_word(ta.row, ta.col, ta.value));
        end
        for (; j < term_len[STORE_B]; j++) begin
            tb = terms[STORE_B][j];
            run_q.push_back(term_word(tb.row, tb.col, tb.value));
        end
        if (run_q.size() == 0) begin
            // Every term cancelled or both stores were empty: one word without a term.
            w = term_word('0, '0, '0);
            w.has_term = 1'b0;
        end else begin
            w = run_q.pop_back();
            w.count = COUNT_PORT_W'(run_q.size() + 1);
        end
        w.last = 1'b1;
        run_q.push_back(w);
        foreach (run_q[k]) begin
            sum_word_q.push_back(run_q[k]);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            term_len[STORE_A] = 0;
            term_len[STORE_B] = 0;
            dropped_load = 1'b0;
            sum_word_q.delete();
        end else begin
            if (i_valid) begin
                if (sum_word_q.size() == 0) begin
                    o_mismatch_count++;
                    if (o_mismatch_count <= REPORT_LIMIT) begin
                        $display("Result word with nothing pending: has_term=%0b row=%0d col=%0d",
                                 i_has_term, i_out_row, i_out_col,
                                 " value=%0d last=%0b count=%0d overflow=%0b",
                                 i_out_value, i_last, i_term_count, i_overflow);
                    end
                end else begin
                    want = sum_word_q.pop_front();
                    if (want.has_term !== i_has_term || want.row !== i_out_row
                            || want.col !== i_out_col || want.value !== i_out_value
                            || want.last !== i_last || want.count !== i_term_count
                            || want.overflow !== i_overflow) begin
                        o_mismatch_count++;
                        if (o_mismatch_count <= REPORT_LIMIT) begin
                            $display("Result word mismatch at %0t:", $realtime);
                            $display("  expected has_term=%0b row=%0d col=%0d value=%0d",
                                     want.has_term, want.row, want.col, want.value,
                                     " last=%0b count=%0d overflow=%0b",
                                     want.last, want.count, want.overflow);
                            $display("  actual   has_term=%0b row=%0d col=%0d value=%0d",
                                     i_has_term, i_out_row, i_out_col, i_out_value,
                                     " last=%0b count=%0d overflow=%0b",
                                     i_last, i_term_count, i_overflow);
                        end
                    end
                end
            end
            if (start && !busy) begin
                case (t_opcode'(i_opcode))
                    OP_CLEAR: begin
                        term_len[STORE_A] = 0;
                        term_len[STORE_B] = 0;
                        dropped_load = 1'b0;
                    end
                    OP_LOAD_A, OP_LOAD_B: begin
                        store_sel = (t_opcode'(i_opcode) == OP_LOAD_A) ? STORE_A : STORE_B;
                        // A zero value is not a term and leaves the overflow flag alone.
                        if (i_term_value != 0) begin
                            if (term_len[store_sel] >= MAX_TERMS) begin
                                dropped_load = 1'b1;
                            end else begin
                                terms[store_sel][term_len[store_sel]] =
                                    '{row: i_term_row, col: i_term_col, value: i_term_value};
                                term_len[store_sel]++;
                            end
                        end
                    end
                    OP_RUN: begin
                        merge_stores();
                    end
                    default: begin
                    end
                endcase
            end
        end
        o_pending_words = sum_word_q.size();
    end

endmodule

// ===== tb/sparse_triplet_merge_add_top_test.sv =====
// Testbench top for sparse_triplet_merge_add_top: drives load, clear and run commands
// and gives the verdict. Depends on stma_pkg and sparse_triplet_merge_add_checker.
`timescale 1ns / 1ps

module sparse_triplet_merge_add_top_test;
    import stma_pkg::*;

    // Even when every pair cancels, the engine still walks the stores, so a quiet stretch
    // far beyond the longest run, that of two full stores, is a hang.
    localparam int IDLE_LIMIT   = 2000;
    localparam int TAIL_CYCLES  = 80;
    localparam int RANDOM_ITEMS = 200;

    typedef bit [15:0] t_key_q[$];

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           start;
    logic                           busy;
    logic [1:0]                     opcode;
    logic [ROW_PORT_W-1:0]          term_row;
    logic [ROW_PORT_W-1:0]          term_col;
    logic signed [VALUE_PORT_W-1:0] term_value;
    logic                           o_valid;
    logic                           o_has_term;
    logic [ROW_PORT_W-1:0]          o_out_row;
    logic [ROW_PORT_W-1:0]          o_out_col;
    logic signed [SUM_PORT_W-1:0]   o_out_value;
    logic                           o_last;
    logic [COUNT_PORT_W-1:0]        o_term_count;
    logic                           o_overflow;
    int                             mismatch_count;
    int                             pending_words;
    int                             idle_pct;
    int                             items_sent;
    int                             quiet_cycles;

    // 4 ns clock.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    sparse_triplet_merge_add_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_opcode     (opcode),
        .i_term_row   (term_row),
        .i_term_col   (term_col),
        .i_term_value (term_value),
        .o_valid      (o_valid),
        .o_has_term   (o_has_term),
        .o_out_row    (o_out_row),
        .o_out_col    (o_out_col),
        .o_out_value  (o_out_value),
        .o_last       (o_last),
        .o_term_count (o_term_count),
        .o_overflow   (o_overflow)
    );

    sparse_triplet_merge_add_checker checker_inst (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_opcode         (opcode),
        .i_term_row       (term_row),
        .i_term_col       (term_col),
        .i_term_value     (term_value),
        .i_valid          (o_valid),
        .i_has_term       (o_has_term),
        .i_out_row        (o_out_row),
        .i_out_col        (o_out_col),
        .i_out_value      (o_out_value),
        .i_last           (o_last),
        .i_term_count     (o_term_count),
        .i_overflow       (o_overflow),
        .o_mismatch_count (mismatch_count),
        .o_pending_words  (pending_words)
    );

    // The watchdog restarts whenever a command word or a result word moves.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Nonzero term value with the two extremes and minus one weighted up.
    function automatic logic signed [VALUE_PORT_W-1:0] rand_value();
        logic signed [VALUE_PORT_W-1:0] v;
        case ($urandom_range(0, 7))
            0: v = 16'sh8000;
            1: v = 16'sh7FFF;
            2: v = -16'sd1;
            default: v = VALUE_PORT_W'($urandom);
        endcase
        if (v == 0) begin
            v = 16'sd1;
        end
        return v;
    endfunction

    // Adds n random positions to the seed set and returns the set sorted in row-major
    // order without repeats. A narrow set uses rows 0..3 and columns 0..7 only, so that
    // positions of the two stores collide often.
    function automatic t_key_q pick_keys(t_key_q seed, int n, bit narrow);
        t_key_q raw;
        t_key_q keys;
        raw = seed;
        for (int k = 0; k < n; k++) begin
            if (narrow) begin
                raw.push_back({6'd0, 2'($urandom_range(0, 3)), 5'd0, 3'($urandom_range(0, 7))});
            end else begin
                raw.push_back(16'($urandom));
            end
        end
        raw.sort();
        foreach (raw[k]) begin
            if (keys.size() == 0 || keys[$] != raw[k]) begin
                keys.push_back(raw[k]);
            end
        end
        return keys;
    endfunction

    // Sends one command word. The sender may sit idle first, as the current idle
    // percentage says; start then stays high until the block takes the word.
    // Called and left at a falling edge.
    task automatic issue(t_opcode op, bit [15:0] key, logic signed [VALUE_PORT_W-1:0] value);
        bit taken;
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start      <= 1'b1;
        opcode     <= op;
        term_row   <= key[15:8];
        term_col   <= key[7:0];
        term_value <= value;
        taken = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            taken = !busy;
            @(negedge i_clk);
        end
        items_sent++;
    endtask

    // Holds the sender off until every predicted result word has come out.
    // At least one edge passes, so start is never lowered and raised in one step.
    task automatic drain();
        start <= 1'b0;
        do begin
            @(negedge i_clk);
        end while (pending_words != 0);
    endtask

    initial begin
        t_key_q                         a_keys;
        t_key_q                         b_keys;
        t_key_q                         shared;
        logic signed [VALUE_PORT_W-1:0] a_value_at [bit [15:0]];
        logic signed [VALUE_PORT_W-1:0] v;
        int                             na;
        int                             nb;
        int                             ia;
        int                             ib;
        int                             share_pct;
        int                             seq;
        int                             random_start;
        bit                             big;
        bit                             narrow;

        i_rst_n    = 1'b0;
        start      = 1'b0;
        opcode     = OP_CLEAR;
        term_row   = '0;
        term_col   = '0;
        term_value = '0;
        idle_pct   = 0;
        items_sent = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part. A run right after reset sees two empty stores and must give
        // the single word without a term.
        issue(OP_RUN, 16'h0000, 16'sd0);

        // Extreme positions and values. Equal positions add up to the most negative and
        // the most positive sums, one pair cancels and must vanish, a zero load is ignored.
        issue(OP_LOAD_A, 16'h0000, 16'sh8000);
        issue(OP_LOAD_A, 16'h00FF, 16'sh7FFF);
        issue(OP_LOAD_A, 16'h4242, 16'sd0);
        issue(OP_LOAD_A, 16'hFFFF, 16'sh7FFF);
        issue(OP_LOAD_B, 16'h0000, 16'sh8000);
        issue(OP_LOAD_B, 16'h00FF, 16'sh7FFF);
        issue(OP_LOAD_B, 16'h8007, 16'sd1);
        issue(OP_LOAD_B, 16'hFFFF, -16'sd32767);
        issue(OP_RUN, 16'hFFFF, 16'sh7FFF);
        // The stores survive a run, so a second run repeats the same words.
        issue(OP_RUN, 16'h0000, 16'sd0);

        // Terms loaded out of row-major order go through the same compare rule.
        issue(OP_CLEAR, 16'hFFFF, -16'sd1);
        issue(OP_LOAD_A, 16'h0505, 16'sd3);
        issue(OP_LOAD_A, 16'h0202, 16'sd4);
        issue(OP_LOAD_B, 16'h0303, 16'sd7);
        issue(OP_RUN, 16'h0000, 16'sd0);

        // A single pair that cancels leaves an empty sum after a clear.
        issue(OP_CLEAR, 16'h0000, 16'sd0);
        issue(OP_LOAD_A, 16'h0101, 16'sd5);
        issue(OP_LOAD_B, 16'h0101, -16'sd5);
        issue(OP_RUN, 16'h0000, 16'sd0);
        drain();

        // Random part. Most sequences are well formed: clear, two row-major term sets
        // that often share positions, then one or two runs. Now and then a burst of random
        // commands runs over whatever the stores hold. The sender idles in phases,
        // and each phase begins with every result word drained.
        random_start = items_sent;
        seq = 0;
        while (items_sent - random_start < RANDOM_ITEMS) begin
            if (seq % 4 == 0) begin
                drain();
                case ((seq / 4) % 3)
                    0: idle_pct = 0;
                    1: idle_pct = 59;
                    default: idle_pct = 26;
                endcase
            end
            if (seq > 0 && $urandom_range(0, 99) < 15) begin
                repeat ($urandom_range(3, 8)) begin
                    v = ($urandom_range(0, 3) == 0) ? 16'sd0 : rand_value();
                    issue(t_opcode'($urandom_range(0, 3)), 16'($urandom), v);
                end
            end else begin
                // The first sequence loads large sets with no deliberately shared positions, which
                // aims at the longest run; any large set may push past a full store.
                big    = (seq == 0) || ($urandom_range(0, 9) == 0);
                narrow = !big && ($urandom_range(0, 1) == 1);
                case ($urandom_range(0, 2))
                    0: share_pct = 0;
                    1: share_pct = 30;
                    default: share_pct = 70;
                endcase
                if (seq == 0) begin
                    share_pct = 0;
                end
                na = big ? $urandom_range(32, 35) : $urandom_range(0, 10);
                nb = big ? $urandom_range(32, 35) : $urandom_range(0, 10);
                a_keys.delete();
                a_keys = pick_keys(a_keys, na, narrow);
                a_value_at.delete();
                shared.delete();
                foreach (a_keys[k]) begin
                    a_value_at[a_keys[k]] = rand_value();
                    if ($urandom_range(0, 99) < share_pct) begin
                        shared.push_back(a_keys[k]);
                    end
                end
                b_keys = pick_keys(shared, (nb > shared.size()) ? nb - shared.size() : 0,
                                   narrow);
                issue(OP_CLEAR, 16'($urandom), rand_value());
                ia = 0;
                ib = 0;
                while (ia < a_keys.size() || ib < b_keys.size()) begin
                    if (ib >= b_keys.size()
                            || (ia < a_keys.size() && $urandom_range(0, 1) == 1)) begin
                        issue(OP_LOAD_A, a_keys[ia], a_value_at[a_keys[ia]]);
                        ia++;
                    end else begin
                        // A shared position often gets the negated value so the pair cancels.
                        v = rand_value();
                        if (a_value_at.exists(b_keys[ib]) && $urandom_range(0, 99) < 40
                                && a_value_at[b_keys[ib]] != 16'sh8000) begin
                            v = -a_value_at[b_keys[ib]];
                        end
                        issue(OP_LOAD_B, b_keys[ib], v);
                        ib++;
                    end
                end
                issue(OP_RUN, 16'($urandom), rand_value());
                if ($urandom_range(0, 3) == 0) begin
                    issue(OP_RUN, 16'($urandom), rand_value());
                end
            end
            seq++;
        end

        // Let every predicted word arrive, then give any stray word time to show up.
        drain();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (mismatch_count == 0 && pending_words == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== sparse_triplet_merge_add_top.f =====
+incdir+hw/rtl
hw/rtl/stma_pkg.sv
hw/rtl/stma_ram.sv
hw/rtl/sparse_triplet_merge_add_top.sv
tb/sparse_triplet_merge_add_checker.sv
tb/sparse_triplet_merge_add_top_test.sv
